FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int ADDR_BITS    = 24;
	localparam int HEADER_BYTES = 32;
	localparam int LIVE_BITS    = 7;

	typedef enum logic [1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_FREE    = 2'd1,
		FUNC_REALLOC = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NULL      = 2'd1,
		ST_OOM       = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		func_t                func;
		logic [ADDR_BITS-1:0] req_size;
		logic [ADDR_BITS-1:0] user_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr_out;
		logic [ADDR_BITS-1:0] copy_from;
		logic [ADDR_BITS-1:0] copy_len;
		status_t              status;
		logic [LIVE_BITS-1:0] live_allocs;
	} rsp_t;

	// one entry of the block table
	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] size;
		logic                 free;
	} blk_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan_start;
		logic    scan_fit;
		logic    take;
		logic    append;
		logic    keep;
		logic    release_blk;
		logic    set_status;
		status_t code;
		logic    push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  size_zero;
		logic  addr_zero;
		logic  moving;
		logic  scan_done;
		logic  scan_hit;
		logic  fits_old;
		logic  oom;
		logic  out_free;
	} sts_t;

endpackage

FILE: rtl/ffba_dp.sv
`timescale 1ns / 1ps

module ffba_dp import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req_data,
	input  logic                 cfg_valid,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  logic                 rsp_stall,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 rsp_valid,
	output rsp_t                 rsp_data
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0]        FULL = CW'(MAX_BLOCKS);
	localparam logic [ADDR_BITS-1:0] HDR  = ADDR_BITS'(HEADER_BYTES);

	blk_t mem [MAX_BLOCKS];

	// current item
	func_t                func_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS:0]   total_q;

	// heap state
	logic [ADDR_BITS-1:0] cap_q;
	logic [ADDR_BITS-1:0] break_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        live_q;

	// scan engine
	logic          run_q;
	logic          mode_fit_q;
	logic [CW-1:0] idx_q;
	logic          pend_s1;
	logic [AW-1:0] pidx_s1;
	blk_t          rd_s1;

	// blocks found by the two kinds of scan
	logic [AW-1:0] fit_idx_q;
	blk_t          fit_q;
	logic [AW-1:0] fnd_idx_q;
	blk_t          fnd_q;

	// result being built
	logic [ADDR_BITS-1:0] res_addr_q;
	logic [ADDR_BITS-1:0] res_cfrom_q;
	logic [ADDR_BITS-1:0] res_clen_q;
	status_t              res_status_q;

	logic                 out_valid_q;
	rsp_t                 out_q;

	logic                 issue;
	logic                 match;
	logic                 hit;
	logic                 done;
	logic [ADDR_BITS+1:0] end_sum;
	logic [ADDR_BITS+1:0] rel_end;
	logic                 pop;
	logic                 moving;
	logic                 we;
	logic [AW-1:0]        wa;
	blk_t                 wd;

	assign issue = run_q && (idx_q < count_q);

	always_comb begin
		if (mode_fit_q) begin
			match = rd_s1.free && (rd_s1.size >= size_q);
		end else begin
			match = !rd_s1.free && (({1'b0, rd_s1.base} + {1'b0, HDR}) == {1'b0, addr_q});
		end
	end

	assign hit  = run_q && pend_s1 && match;
	assign done = run_q && (hit || (!pend_s1 && !issue));

	assign end_sum = {2'b00, break_q} + {1'b0, total_q};
	assign rel_end = {2'b00, fnd_q.base} + {2'b00, HDR} + {2'b00, fnd_q.size};
	// block ends at the break: it is the last one and leaves the table
	assign pop     = (rel_end == {2'b00, break_q});
	assign moving  = (func_q == FUNC_REALLOC) && (addr_q != '0) && (size_q != '0);

	always_comb begin
		sts.func      = func_q;
		sts.size_zero = (size_q == '0);
		sts.addr_zero = (addr_q == '0);
		sts.moving    = moving;
		sts.scan_done = done;
		sts.scan_hit  = hit;
		sts.fits_old  = (fnd_q.size >= size_q);
		sts.oom       = (count_q == FULL) || (end_sum > {2'b00, cap_q});
		sts.out_free  = !out_valid_q || !rsp_stall;
	end

	// table write port
	always_comb begin
		we = 1'b0;
		wa = fnd_idx_q;
		wd = fnd_q;
		if (cmd.take) begin
			we      = 1'b1;
			wa      = fit_idx_q;
			wd      = fit_q;
			wd.free = 1'b0;
		end else if (cmd.append) begin
			we      = 1'b1;
			wa      = count_q[AW-1:0];
			wd.base = break_q;
			wd.size = size_q;
			wd.free = 1'b0;
		end else if (cmd.release_blk && !pop) begin
			we      = 1'b1;
			wd.free = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (issue) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			mode_fit_q <= 1'b0;
			idx_q      <= '0;
			pend_s1    <= 1'b0;
		end else if (cmd.scan_start) begin
			run_q      <= 1'b1;
			mode_fit_q <= cmd.scan_fit;
			idx_q      <= '0;
			pend_s1    <= 1'b0;
		end else if (run_q) begin
			if (done) begin
				run_q   <= 1'b0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pidx_s1 <= idx_q[AW-1:0];
		end
		if (hit) begin
			if (mode_fit_q) begin
				fit_idx_q <= pidx_s1;
				fit_q     <= rd_s1;
			end else begin
				fnd_idx_q <= pidx_s1;
				fnd_q     <= rd_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= ADDR_BITS'(1048576);
			break_q <= '0;
			count_q <= '0;
			live_q  <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.append) begin
				count_q <= count_q + 1'b1;
				break_q <= end_sum[ADDR_BITS-1:0];
				live_q  <= live_q + 1'b1;
			end else if (cmd.take) begin
				live_q <= live_q + 1'b1;
			end else if (cmd.release_blk) begin
				if (pop) begin
					count_q <= count_q - 1'b1;
					break_q <= fnd_q.base;
				end
				if (live_q != '0) begin
					live_q <= live_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= req_data.func;
			size_q       <= req_data.req_size;
			addr_q       <= req_data.user_addr;
			total_q      <= {1'b0, req_data.req_size} + {1'b0, HDR};
			res_addr_q   <= '0;
			res_cfrom_q  <= '0;
			res_clen_q   <= '0;
			res_status_q <= ST_OK;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.code;
			end
			if (cmd.take) begin
				res_addr_q <= fit_q.base + HDR;
			end else if (cmd.append) begin
				res_addr_q <= break_q + HDR;
			end else if (cmd.keep) begin
				res_addr_q <= addr_q;
			end
			if (cmd.release_blk && moving) begin
				res_cfrom_q <= addr_q;
				res_clen_q  <= fnd_q.size;
			end
		end
	end

	// output register, refilled while the last beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.addr_out    <= res_addr_q;
			out_q.copy_from   <= res_cfrom_q;
			out_q.copy_len    <= res_clen_q;
			out_q.status      <= res_status_q;
			out_q.live_allocs <= LIVE_BITS'(live_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

FILE: rtl/ffba_ctrl.sv
`timescale 1ns / 1ps

module ffba_ctrl import ffba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_DECODE  = 8'b0000_0010,
		S_FIND    = 8'b0000_0100,
		S_FOUND   = 8'b0000_1000,
		S_FIT     = 8'b0001_0000,
		S_TAKE    = 8'b0010_0000,
		S_RELEASE = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					FUNC_ALLOC, FUNC_REALLOC: begin
						if (sts.func == FUNC_REALLOC && !sts.addr_zero && !sts.size_zero) begin
							cmd.scan_start = 1'b1;
							state_d        = S_FIND;
						end else if (sts.size_zero) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_NULL;
							state_d        = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							cmd.scan_fit   = 1'b1;
							state_d        = S_FIT;
						end
					end
					FUNC_FREE: begin
						if (sts.addr_zero) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_NULL;
							state_d        = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_FIND;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_FIND: begin
				if (sts.scan_done) begin
					if (sts.scan_hit) begin
						state_d = S_FOUND;
					end else begin
						cmd.set_status = 1'b1;
						cmd.code       = ST_NOT_FOUND;
						state_d        = S_DONE;
					end
				end
			end
			S_FOUND: begin
				if (sts.func == FUNC_FREE) begin
					cmd.release_blk = 1'b1;
					state_d         = S_DONE;
				end else if (sts.fits_old) begin
					cmd.keep = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_fit   = 1'b1;
					state_d        = S_FIT;
				end
			end
			S_FIT: begin
				if (sts.scan_done) begin
					if (sts.scan_hit) begin
						state_d = S_TAKE;
					end else if (sts.oom) begin
						cmd.set_status = 1'b1;
						cmd.code       = ST_OOM;
						state_d        = S_DONE;
					end else begin
						cmd.append = 1'b1;
						state_d    = sts.moving ? S_RELEASE : S_DONE;
					end
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d  = sts.moving ? S_RELEASE : S_DONE;
			end
			S_RELEASE: begin
				// old block goes after the new one is placed
				cmd.release_blk = 1'b1;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// channel  direction  handshake            beat
// req      in         req_valid/req_stall  req_t: func, req_size, user_addr
// rsp      out        rsp_valid/rsp_stall  rsp_t: addr_out, copy_from, copy_len, status,
//                                          live_allocs
// cfg      in         cfg_valid/cfg_ready  heap_capacity
//
// an item walks the table at most once; a reallocate that moves walks it twice, once to
// find the old block and once to find a free one
// the walk reads one table entry per cycle through the single read port of the block memory
// after reset the table is empty and no clearing pass runs; entries are read only once written
// one item at a time; the next one is taken while the last result waits in the output
// register, and an item only waits at its end if that register is still full

module first_fit_block_allocator_top import ffba_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ADDR_BITS-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

endmodule
